// ----- rtl/core/irf_pkg.sv -----
// ----------------------------------------------------------------------------
// Integer radix formatter package
// Shared widths, request codes, controller states and ASCII helpers.
// ----------------------------------------------------------------------------
package irf_pkg;

	localparam int MAX_PRECISION = 60;
	localparam int VALUE_W       = 64;
	localparam int BIT_CNT_W     = $clog2(VALUE_W);
	localparam int NUM_DIGITS    = 22;
	localparam int DIG_CNT_W     = $clog2(NUM_DIGITS + 1);
	localparam int PREC_W        = 6;
	localparam int CHAR_W        = 8;
	localparam int TOTAL_W       = 7;

	localparam int IN_TDATA_W    = 80;
	localparam int IN_TUSER_W    = 5;
	localparam int OUT_TDATA_W   = 8;

	typedef enum logic [2:0] {
		KIND_SDEC = 3'd0,
		KIND_UDEC = 3'd1,
		KIND_OCT  = 3'd2,
		KIND_HEXL = 3'd3,
		KIND_HEXU = 3'd4,
		KIND_PTR  = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		LEN_DEFAULT = 2'd0,
		LEN_SHORT   = 2'd1,
		LEN_LONG    = 2'd2
	} len_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SETUP,
		ST_EMIT
	} state_t;

	typedef logic [3:0] digit_t;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
	localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
	localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_F_LO  = 8'h66;
	localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_F_UP  = 8'h46;

	// ASCII character of one digit; letters for digits above nine.
	function automatic logic [CHAR_W-1:0] digit_char(digit_t d, logic upper);
		logic [CHAR_W-1:0] d8;
		d8 = {4'd0, d};
		if (d > 4'd9) begin
			digit_char = (upper ? CH_A_UP : CH_A_LO) + d8 - 8'd10;
		end else begin
			digit_char = CH_ZERO + d8;
		end
	endfunction

endpackage

// ----- rtl/core/integer_radix_formatter_top.sv -----
// ----------------------------------------------------------------------------
// Integer radix formatter
// Turns one integer conversion request into its ASCII characters.
// ----------------------------------------------------------------------------
// Usage:
// A request enters on the slave stream: tuser carries the conversion kind and
// the length modifier, tdata carries the raw value, the precision and the
// plus, space and hash flags. The master stream returns the characters of the
// formatted number, one per item, with tlast set on the final character. A
// request that yields no character (zero value with precision zero, no sign
// and no pointer prefix, or an unknown conversion kind) returns nothing.
// Operation: the value is shifted bit by bit into a row of digit cells, one
// bit per cycle for all 64 bits; a setup step then lays out the characters.
// Characters then leave at one per cycle while the receiver does not stall.
// An unknown conversion kind is taken and dropped without conversion. A new
// request is taken as soon as the last character has been loaded into the
// output register, even while that character waits.
// Reset clears the controller and the output valid flag; the block then
// waits idle for a request. A stalled receiver holds the current character
// in the output register and pauses character generation; nothing is lost.
// ----------------------------------------------------------------------------
module integer_radix_formatter_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// value [63:0], precision [70:64], plus_sign [71], space_sign [72],
	// alt_form [73], unused [79:74]
	input  logic [irf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// req_type [2:0], length_mod [4:3]
	input  logic [irf_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// out_char [7:0]
	output logic [irf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// is_last
	output logic                             m_axis_tlast
);

	// Request fields as they arrive.
	logic [2:0]                      kind_in;
	logic [1:0]                      lmod_in;
	logic [irf_pkg::VALUE_W-1:0]     value_in;
	logic [6:0]                      prec_in;
	logic                            plus_in;
	logic                            space_in;
	logic                            alt_in;

	assign kind_in  = s_axis_tuser[2:0];
	assign lmod_in  = s_axis_tuser[4:3];
	assign value_in = s_axis_tdata[63:0];
	assign prec_in  = s_axis_tdata[70:64];
	assign plus_in  = s_axis_tdata[71];
	assign space_in = s_axis_tdata[72];
	assign alt_in   = s_axis_tdata[73];

	// Controller state and request registers.
	irf_pkg::state_t                 state_q, state_d;
	logic [2:0]                      kind_q;
	logic                            neg_q;
	logic                            plus_q;
	logic                            space_q;
	logic                            alt_q;
	logic                            prec_given_q;
	logic [irf_pkg::PREC_W-1:0]      prec_val_q;
	logic [irf_pkg::VALUE_W-1:0]     mag_q;
	logic [irf_pkg::BIT_CNT_W-1:0]   bit_cnt_q;
	irf_pkg::digit_t                 digits_q [irf_pkg::NUM_DIGITS];
	logic [irf_pkg::DIG_CNT_W-1:0]   ndig_q;
	logic [1:0]                      pre_left_q;
	logic [irf_pkg::PREC_W-1:0]      zero_left_q;
	logic [irf_pkg::DIG_CNT_W-1:0]   dig_left_q;
	logic                            m_valid_q;
	logic [irf_pkg::CHAR_W-1:0]      m_char_q;
	logic                            m_last_q;

	logic                            accept;
	logic                            kind_ok;

	assign kind_ok = (kind_in <= irf_pkg::KIND_PTR);
	assign accept  = s_axis_tvalid && s_axis_tready;

	// ------------------------------------------------------------------------
	// Argument selection: width from the length modifier, sign or zero
	// extension, then the magnitude that is shown.
	// ------------------------------------------------------------------------
	logic [irf_pkg::VALUE_W-1:0]     sx;
	logic [irf_pkg::VALUE_W-1:0]     mag_in;
	logic                            neg_in;
	logic                            prec_given_in;
	logic [irf_pkg::PREC_W-1:0]      prec_val_in;

	always_comb begin
		case (kind_in)
			irf_pkg::KIND_UDEC: begin
				case (lmod_in)
					irf_pkg::LEN_SHORT: sx = {48'd0, value_in[15:0]};
					irf_pkg::LEN_LONG:  sx = value_in;
					default:            sx = {32'd0, value_in[31:0]};
				endcase
			end
			irf_pkg::KIND_PTR: sx = value_in;
			default: begin
				case (lmod_in)
					irf_pkg::LEN_SHORT: sx = {{48{value_in[15]}}, value_in[15:0]};
					irf_pkg::LEN_LONG:  sx = value_in;
					default:            sx = {{32{value_in[31]}}, value_in[31:0]};
				endcase
			end
		endcase

		neg_in = (kind_in != irf_pkg::KIND_UDEC) && sx[63];

		if (kind_in == irf_pkg::KIND_SDEC) begin
			mag_in = neg_in ? (64'd0 - sx) : sx;
		end else if (kind_in == irf_pkg::KIND_UDEC) begin
			mag_in = sx;
		end else if (neg_in && !(kind_in != irf_pkg::KIND_PTR && lmod_in == irf_pkg::LEN_LONG)) begin
			// Negative octal or hex below long width, and any negative pointer, shows the 32-bit two's complement.
			mag_in = {32'd0, sx[31:0]};
		end else begin
			mag_in = sx;
		end

		// Any negative precision means none was given; large ones saturate.
		prec_given_in = !prec_in[6];
		prec_val_in   = (prec_in[5:0] > irf_pkg::PREC_W'(irf_pkg::MAX_PRECISION)) ?
			irf_pkg::PREC_W'(irf_pkg::MAX_PRECISION) : prec_in[5:0];
	end

	// ------------------------------------------------------------------------
	// Digit cells. Each cycle the next magnitude bit enters cell 0 and every
	// cell doubles its digit plus the carry from below, folding back by the
	// radix. A cell's carry out depends only on its own digit, so the row
	// settles without a ripple chain.
	// ------------------------------------------------------------------------
	logic [3:0]                      base_half;
	logic [4:0]                      base5;
	logic [irf_pkg::NUM_DIGITS-1:0]  carry;
	logic [irf_pkg::NUM_DIGITS-1:0]  cin;
	irf_pkg::digit_t                 next_dig [irf_pkg::NUM_DIGITS];
	logic [4:0]                      dbl;
	logic                            grow;

	always_comb begin
		case (kind_q)
			irf_pkg::KIND_SDEC, irf_pkg::KIND_UDEC: base_half = 4'd5;
			irf_pkg::KIND_OCT:                      base_half = 4'd4;
			default:                                base_half = 4'd8;
		endcase
		base5 = {base_half, 1'b0};

		for (int i = 0; i < irf_pkg::NUM_DIGITS; i++) begin
			carry[i] = (digits_q[i] >= base_half);
		end
		cin[0] = mag_q[irf_pkg::VALUE_W-1];
		for (int i = 1; i < irf_pkg::NUM_DIGITS; i++) begin
			cin[i] = carry[i-1];
		end
		for (int i = 0; i < irf_pkg::NUM_DIGITS; i++) begin
			dbl         = {digits_q[i], cin[i]} - (carry[i] ? base5 : 5'd0);
			next_dig[i] = dbl[3:0];
		end

		// Cells above the count are zero, so only the cell at the count can
		// turn nonzero when the row is updated.
		grow = (ndig_q < irf_pkg::DIG_CNT_W'(irf_pkg::NUM_DIGITS)) && cin[ndig_q];
	end

	// ------------------------------------------------------------------------
	// Layout of the characters: prefix, zero padding, digits.
	// ------------------------------------------------------------------------
	logic [irf_pkg::DIG_CNT_W-1:0]   nd_eff;
	logic [irf_pkg::PREC_W-1:0]      zeros;
	logic                            mag_nz;
	logic [1:0]                      npre;

	always_comb begin
		mag_nz = (ndig_q != '0);
		if (!mag_nz) begin
			// A zero value shows one digit unless the precision is exactly zero.
			nd_eff = (prec_given_q && prec_val_q == '0) ? '0 : irf_pkg::DIG_CNT_W'(1);
		end else begin
			nd_eff = ndig_q;
		end

		if (prec_given_q && prec_val_q > irf_pkg::PREC_W'(nd_eff)) begin
			zeros = prec_val_q - irf_pkg::PREC_W'(nd_eff);
		end else begin
			zeros = '0;
		end

		case (kind_q)
			irf_pkg::KIND_SDEC: npre = (neg_q || plus_q || space_q) ? 2'd1 : 2'd0;
			irf_pkg::KIND_OCT:  npre = (alt_q && mag_nz && zeros == '0) ? 2'd1 : 2'd0;
			irf_pkg::KIND_HEXL,
			irf_pkg::KIND_HEXU: npre = (alt_q && mag_nz) ? 2'd2 : 2'd0;
			irf_pkg::KIND_PTR:  npre = 2'd2;
			default:            npre = 2'd0;
		endcase
	end

	// ------------------------------------------------------------------------
	// Character emission.
	// ------------------------------------------------------------------------
	logic [irf_pkg::TOTAL_W-1:0]     total;
	logic                            emit_adv;
	logic [irf_pkg::CHAR_W-1:0]      emit_char;
	logic [irf_pkg::DIG_CNT_W-1:0]   dig_idx;

	assign total    = irf_pkg::TOTAL_W'(pre_left_q) + irf_pkg::TOTAL_W'(zero_left_q)
		+ irf_pkg::TOTAL_W'(dig_left_q);
	assign emit_adv = (state_q == irf_pkg::ST_EMIT) && (total != '0)
		&& (!m_valid_q || m_axis_tready);
	assign dig_idx  = dig_left_q - irf_pkg::DIG_CNT_W'(1);

	always_comb begin
		if (pre_left_q == 2'd2) begin
			emit_char = irf_pkg::CH_ZERO;
		end else if (pre_left_q == 2'd1) begin
			case (kind_q)
				irf_pkg::KIND_SDEC: emit_char = neg_q ? irf_pkg::CH_MINUS :
					(plus_q ? irf_pkg::CH_PLUS : irf_pkg::CH_SPACE);
				irf_pkg::KIND_OCT:  emit_char = irf_pkg::CH_ZERO;
				irf_pkg::KIND_HEXU: emit_char = irf_pkg::CH_X_UP;
				default:            emit_char = irf_pkg::CH_X_LO;
			endcase
		end else if (zero_left_q != '0) begin
			emit_char = irf_pkg::CH_ZERO;
		end else begin
			emit_char = irf_pkg::digit_char(digits_q[dig_idx], kind_q == irf_pkg::KIND_HEXU);
		end
	end

	// ------------------------------------------------------------------------
	// Controller.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= irf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		case (state_q)
			irf_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				// Unknown conversion kinds are taken and dropped.
				if (s_axis_tvalid && kind_ok) begin
					state_d = irf_pkg::ST_CONV;
				end
			end
			irf_pkg::ST_CONV: begin
				if (bit_cnt_q == '0) begin
					state_d = irf_pkg::ST_SETUP;
				end
			end
			irf_pkg::ST_SETUP: begin
				state_d = irf_pkg::ST_EMIT;
			end
			irf_pkg::ST_EMIT: begin
				if (total == '0 || (emit_adv && total == irf_pkg::TOTAL_W'(1))) begin
					state_d = irf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = irf_pkg::ST_IDLE;
			end
		endcase
	end

	// Request and digit datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q       <= kind_in;
			neg_q        <= neg_in;
			plus_q       <= plus_in;
			space_q      <= space_in;
			alt_q        <= alt_in;
			prec_given_q <= prec_given_in;
			prec_val_q   <= prec_val_in;
			mag_q        <= mag_in;
			bit_cnt_q    <= '1;
			ndig_q       <= '0;
			for (int i = 0; i < irf_pkg::NUM_DIGITS; i++) begin
				digits_q[i] <= '0;
			end
		end else if (state_q == irf_pkg::ST_CONV) begin
			mag_q     <= {mag_q[irf_pkg::VALUE_W-2:0], 1'b0};
			bit_cnt_q <= bit_cnt_q - irf_pkg::BIT_CNT_W'(1);
			ndig_q    <= ndig_q + irf_pkg::DIG_CNT_W'(grow);
			for (int i = 0; i < irf_pkg::NUM_DIGITS; i++) begin
				digits_q[i] <= next_dig[i];
			end
		end

		if (state_q == irf_pkg::ST_SETUP) begin
			pre_left_q  <= npre;
			zero_left_q <= zeros;
			dig_left_q  <= nd_eff;
		end else if (emit_adv) begin
			if (pre_left_q != 2'd0) begin
				pre_left_q <= pre_left_q - 2'd1;
			end else if (zero_left_q != '0) begin
				zero_left_q <= zero_left_q - irf_pkg::PREC_W'(1);
			end else begin
				dig_left_q <= dig_idx;
			end
		end
	end

	// Output register: parts character generation from the receiver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit_adv) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_adv) begin
			m_char_q <= emit_char;
			m_last_q <= (total == irf_pkg::TOTAL_W'(1));
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_char_q;
	assign m_axis_tlast  = m_last_q;

endmodule

// ----- rtl/core/irf_checker.sv -----
// ----------------------------------------------------------------------------
// Integer radix formatter port checker
// Watches the stream ports of the formatter and flags illegal behavior.
// ----------------------------------------------------------------------------
module irf_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [irf_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [irf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input logic                             m_axis_tlast
);

	logic [irf_pkg::CHAR_W-1:0] c;
	assign c = m_axis_tdata;

	// A stalled item stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output item withdrawn while stalled");

	// A stalled item keeps its character and last flag.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output item changed while stalled");

	// Only digits, hex letters, sign characters and the radix marker appear.
	a_legal_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			(c >= irf_pkg::CH_ZERO && c <= irf_pkg::CH_NINE) ||
			(c >= irf_pkg::CH_A_LO && c <= irf_pkg::CH_F_LO) ||
			(c >= irf_pkg::CH_A_UP && c <= irf_pkg::CH_F_UP) ||
			c == irf_pkg::CH_MINUS || c == irf_pkg::CH_PLUS ||
			c == irf_pkg::CH_SPACE || c == irf_pkg::CH_X_LO || c == irf_pkg::CH_X_UP)
		else $error("illegal output character");

	// A known conversion occupies the block: no second request right after.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser[2:0] <= irf_pkg::KIND_PTR)
		|=> !s_axis_tready)
		else $error("request taken while the previous one is converting");

endmodule

bind integer_radix_formatter_top irf_checker u_irf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
